// ----- rtl/lfu_pkg.sv -----
// Shared types and constants for the LFU cache controller and datapath.
`default_nettype none

package lfu_pkg;

   // Request kinds carried on the request tuser bit.
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
   localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;
   localparam logic [31:0] COUNT_ONE  = 32'd1;

   localparam logic [4:0] CAPACITY_RESET = 5'd16;

   // Configuration register byte addresses.
   localparam logic [1:0] CSR_ADDR_CAPACITY = 2'd0;

   // One stored entry: key, value, use count and the stamp of its last count change.
   typedef struct packed {
      logic [31:0] key;
      logic [31:0] value;
      logic [31:0] count;
      logic [63:0] stamp;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } ctrl_state_type;

   typedef struct packed {
      logic start;
      logic rd_en;
      logic commit;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

// ----- rtl/lfu_ctrl.sv -----
// Controller state machine that sequences the entry scan and the commit of one item.
`default_nettype none

module lfu_ctrl #(
   parameter int ENTRIES = 16,
   parameter int AW      = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               out_free,
   output lfu_pkg::ctrl_cmd_type   cmd,
   output logic [AW-1:0]           rd_addr
);
   import lfu_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [AW-1:0]  idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      req_ready  = 1'b0;
      cmd.start  = 1'b0;
      cmd.rd_en  = 1'b0;
      cmd.commit = 1'b0;
      rd_addr    = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               idx_in    = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            if (idx_ff == AW'(ENTRIES - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // The last entry read is evaluated in this cycle.
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/lfu_dpath.sv -----
// Datapath: entry memory, valid bits, scan trackers, update logic and result register.
`default_nettype none

module lfu_dpath #(
   parameter int ENTRIES = 16,
   parameter int AW      = 4,
   parameter int OW      = 5
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  lfu_pkg::ctrl_cmd_type  cmd,
   input  wire logic [AW-1:0]     rd_addr,
   input  wire logic [4:0]        capacity,
   input  wire logic              req_kind,
   input  wire logic [31:0]       req_key,
   input  wire logic [31:0]       req_value,
   output logic                   out_free,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_hit,
   output logic [31:0]            rsp_read_value,
   output logic                   rsp_evicted,
   output logic [31:0]            rsp_evicted_key
);
   import lfu_pkg::*;

   localparam int CW = (OW > 5) ? OW : 5;

   entry_type mem [ENTRIES];
   entry_type rdata_ff;
   logic      eval_ff;
   logic [AW-1:0] eidx_ff;

   logic        kind_ff;
   logic [31:0] key_ff, value_ff;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [OW-1:0]      occ_ff, occ_in;
   logic [63:0]        stamp_ff, stamp_in;

   logic          match_ff, match_in;
   logic [AW-1:0] match_idx_ff, match_idx_in;
   entry_type     match_ent_ff, match_ent_in;
   logic          best_ff, best_in;
   logic [AW-1:0] best_idx_ff, best_idx_in;
   logic [95:0]   best_rank_ff, best_rank_in;
   logic [31:0]   best_key_ff, best_key_in;
   logic          free_ff, free_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        hit_ff, hit_in;
   logic [31:0] rd_ff, rd_in;
   logic        ev_ff, ev_in;
   logic [31:0] evk_ff, evk_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   entry_type     mem_wdata;

   logic          ent_valid;
   logic [CW-1:0] cap_ext, eff_cap;
   logic          full, evict, ins_ok;
   logic [AW-1:0] ins_idx;

   // Entry memory: one write port for the commit, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
      eidx_ff <= rd_addr;
      if (cmd.start) begin
         kind_ff  <= req_kind;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      match_idx_ff <= match_idx_in;
      match_ent_ff <= match_ent_in;
      best_idx_ff  <= best_idx_in;
      best_rank_ff <= best_rank_in;
      best_key_ff  <= best_key_in;
      free_idx_ff  <= free_idx_in;
      hit_ff       <= hit_in;
      rd_ff        <= rd_in;
      ev_ff        <= ev_in;
      evk_ff       <= evk_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eval_ff      <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         stamp_ff     <= '0;
         match_ff     <= 1'b0;
         best_ff      <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         eval_ff      <= cmd.rd_en;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         stamp_ff     <= stamp_in;
         match_ff     <= match_in;
         best_ff      <= best_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Scan trackers: first key match, lowest-ranked valid entry, first free slot.
   always_comb begin
      ent_valid    = valid_ff[eidx_ff];
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      match_ent_in = match_ent_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      best_rank_in = best_rank_ff;
      best_key_in  = best_key_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      if (cmd.start) begin
         match_in = 1'b0;
         best_in  = 1'b0;
         free_in  = 1'b0;
      end else if (eval_ff) begin
         if (ent_valid && !match_ff && (rdata_ff.key == key_ff)) begin
            match_in     = 1'b1;
            match_idx_in = eidx_ff;
            match_ent_in = rdata_ff;
         end
         // Count first, then the stamp of reaching that count, oldest wins.
         if (ent_valid && (!best_ff || ({rdata_ff.count, rdata_ff.stamp} < best_rank_ff))) begin
            best_in      = 1'b1;
            best_idx_in  = eidx_ff;
            best_rank_in = {rdata_ff.count, rdata_ff.stamp};
            best_key_in  = rdata_ff.key;
         end
         if (!ent_valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = eidx_ff;
         end
      end
   end

   // Effective capacity: zero acts as one, anything above the entry count saturates.
   always_comb begin
      cap_ext = CW'(capacity);
      eff_cap = cap_ext;
      if (cap_ext == '0) begin
         eff_cap = CW'(1);
      end else if (cap_ext > CW'(ENTRIES)) begin
         eff_cap = CW'(ENTRIES);
      end
      full  = CW'(occ_ff) >= eff_cap;
      evict = full && best_ff;
      ins_ok = evict || free_ff;
      if (evict && (!free_ff || (best_idx_ff < free_idx_ff))) begin
         ins_idx = best_idx_ff;
      end else begin
         ins_idx = free_idx_ff;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Commit of one item: update the memory and state, load the result register.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = match_idx_ff;
      mem_wdata = match_ent_ff;
      valid_in  = valid_ff;
      occ_in    = occ_ff;
      stamp_in  = stamp_ff;
      hit_in    = hit_ff;
      rd_in     = rd_ff;
      ev_in     = ev_ff;
      evk_in    = evk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         hit_in = 1'b0;
         rd_in  = '0;
         ev_in  = 1'b0;
         evk_in = '0;
         if (match_ff) begin
            hit_in = 1'b1;
            mem_we = 1'b1;
            if (kind_ff == REQ_PUT) begin
               mem_wdata.value = value_ff;
            end else begin
               rd_in = match_ent_ff.value;
            end
            // A saturated count keeps both its count and its stamp.
            if (match_ent_ff.count != COUNT_MAX) begin
               mem_wdata.count = match_ent_ff.count + 1'b1;
               mem_wdata.stamp = stamp_ff;
               stamp_in        = stamp_ff + 1'b1;
            end
         end else if (kind_ff == REQ_GET) begin
            rd_in = MISS_VALUE;
         end else begin
            if (evict) begin
               ev_in  = 1'b1;
               evk_in = best_key_ff;
               valid_in[best_idx_ff] = 1'b0;
            end
            if (ins_ok) begin
               mem_we          = 1'b1;
               mem_waddr       = ins_idx;
               mem_wdata.key   = key_ff;
               mem_wdata.value = value_ff;
               mem_wdata.count = COUNT_ONE;
               mem_wdata.stamp = stamp_ff;
               stamp_in        = stamp_ff + 1'b1;
               valid_in[ins_idx] = 1'b1;
            end
            occ_in = occ_ff - OW'(evict) + OW'(ins_ok);
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_read_value  = rd_ff;
   assign rsp_evicted     = ev_ff;
   assign rsp_evicted_key = evk_ff;

endmodule

`default_nettype wire

// ----- rtl/lfu_cache.sv -----
// Top level of the LFU cache: stream ports, capacity register, controller and datapath.
`default_nettype none

// Key-value cache of ENTRIES slots with least-frequently-used replacement; among entries
// of equal use count, the one that reached its count earliest is evicted. Each request
// item (get or put) yields exactly one result item. One item is handled at a time; the
// next item is accepted only after the result of the last one is loaded. The entry memory
// has a single read port, so the key search and the victim search walk all ENTRIES slots
// one per cycle. Then a drain state evaluates the last slot, a commit state loads the
// result register, and the idle state accepts the next item. A finished result waits in
// the output register while the next item is accepted; the commit of that next item waits
// for as long as the earlier result is held off on the result side. The capacity
// register (byte address 0, reset 16) limits the number of live entries; zero acts as one
// and values above ENTRIES act as ENTRIES. No clearing pass is needed after reset.

module lfu_cache #(
   parameter int ENTRIES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [31:0] key, [63:32] value
   input  wire logic        req_tuser,   // [0] req_type: 0 get, 1 put
   // Result stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [31:0] read_value, [63:32] evicted_key
   output logic [1:0]       rsp_tuser,   // [0] hit, [1] evicted
   // Configuration port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import lfu_pkg::*;

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OW = $clog2(ENTRIES + 1);

   logic [4:0]     capacity_ff, capacity_in;
   ctrl_cmd_type   cmd;
   logic [AW-1:0]  rd_addr;
   logic           out_free;
   logic           rsp_hit, rsp_evicted;
   logic [31:0]    rsp_read_value, rsp_evicted_key;

   assign csr_pready = 1'b1;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_ADDR_CAPACITY)) begin
         capacity_in = csr_pwdata[4:0];
      end
      csr_prdata = '0;
      if (csr_paddr == CSR_ADDR_CAPACITY) begin
         csr_prdata = {27'd0, capacity_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   lfu_ctrl #(
      .ENTRIES (ENTRIES),
      .AW      (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .out_free  (out_free),
      .cmd       (cmd),
      .rd_addr   (rd_addr)
   );

   lfu_dpath #(
      .ENTRIES (ENTRIES),
      .AW      (AW),
      .OW      (OW)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .rd_addr         (rd_addr),
      .capacity        (capacity_ff),
      .req_kind        (req_tuser),
      .req_key         (req_tdata[31:0]),
      .req_value       (req_tdata[63:32]),
      .out_free        (out_free),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key)
   );

   assign rsp_tdata = {rsp_evicted_key, rsp_read_value};
   assign rsp_tuser = {rsp_evicted, rsp_hit};

endmodule

`default_nettype wire

// ----- verif/lfu_cache_scoreboard.sv -----
`timescale 1ns / 1ps
// Scoreboard for the lfu_cache testbench, with a shadow LFU store that predicts every result.
package lfu_cache_tb_pkg;
   import lfu_pkg::*;

   localparam int SLOTS = 16;

   typedef struct packed {
      logic        hit;
      logic [31:0] read_value;
      logic        evicted;
      logic [31:0] evicted_key;
   } lfu_result_type;

   class lfu_scoreboard;
      logic [4:0]     capacity = CAPACITY_RESET;
      logic           slot_valid [SLOTS] = '{default: 1'b0};
      logic [31:0]    slot_key   [SLOTS] = '{default: '0};
      logic [31:0]    slot_value [SLOTS] = '{default: '0};
      logic [31:0]    slot_count [SLOTS] = '{default: '0};
      logic [63:0]    slot_stamp [SLOTS] = '{default: '0};
      logic [63:0]    next_stamp = '0;
      int unsigned    live_count = 0;
      int unsigned    error_count = 0;
      lfu_result_type expected_results [$];

      function void set_capacity(logic [31:0] data);
         capacity = data[4:0];
      endfunction

      function int unsigned pending_count();
         return expected_results.size();
      endfunction

      // A saturated count keeps both its value and its stamp.
      function void bump_count(int slot);
         if (slot_count[slot] != COUNT_MAX) begin
            slot_count[slot] = slot_count[slot] + 1;
            slot_stamp[slot] = next_stamp;
            next_stamp = next_stamp + 1;
         end
      endfunction

      function lfu_result_type predict_access(logic kind, logic [31:0] key, logic [31:0] value);
         lfu_result_type res;
         int             found;
         int             victim;
         int             free_slot;
         int unsigned    limit;
         res = '0;
         found = -1;
         victim = -1;
         free_slot = -1;
         for (int i = 0; i < SLOTS; i++)
            if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
         if (kind == REQ_GET) begin
            if (found >= 0) begin
               res.hit = 1'b1;
               res.read_value = slot_value[found];
               bump_count(found);
            end else begin
               res.read_value = MISS_VALUE;
            end
         end else if (found >= 0) begin
            res.hit = 1'b1;
            slot_value[found] = value;
            bump_count(found);
         end else begin
            limit = (capacity == 5'd0) ? 1 : ((capacity > SLOTS) ? SLOTS : capacity);
            // Only one victim goes, even when the capacity was lowered below the live count.
            if (live_count >= limit) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_valid[i] && (victim < 0 || slot_count[i] < slot_count[victim] ||
                      (slot_count[i] == slot_count[victim] &&
                       slot_stamp[i] < slot_stamp[victim])))
                     victim = i;
               end
               res.evicted = 1'b1;
               res.evicted_key = slot_key[victim];
               slot_valid[victim] = 1'b0;
               live_count--;
            end
            for (int i = 0; i < SLOTS; i++)
               if (free_slot < 0 && !slot_valid[i]) free_slot = i;
            slot_valid[free_slot] = 1'b1;
            slot_key[free_slot] = key;
            slot_value[free_slot] = value;
            slot_count[free_slot] = COUNT_ONE;
            slot_stamp[free_slot] = next_stamp;
            next_stamp = next_stamp + 1;
            live_count++;
         end
         return res;
      endfunction

      function void note_request(logic kind, logic [31:0] key, logic [31:0] value);
         expected_results.push_back(predict_access(kind, key, value));
      endfunction

      function void check_field(string name, logic [31:0] wanted, logic [31:0] actual);
         if (actual !== wanted) begin
            $error("field %s: expected %08h, actual %08h", name, wanted, actual);
            error_count++;
         end
      endfunction

      function void check_result(logic hit, logic [31:0] read_value, logic evicted,
                                 logic [31:0] evicted_key);
         lfu_result_type oldest;
         if (expected_results.size() == 0) begin
            $error("result item arrived with no request waiting");
            error_count++;
            return;
         end
         oldest = expected_results.pop_front();
         check_field("hit", 32'(oldest.hit), 32'(hit));
         check_field("read_value", oldest.read_value, read_value);
         check_field("evicted", 32'(oldest.evicted), 32'(evicted));
         check_field("evicted_key", oldest.evicted_key, evicted_key);
      endfunction
   endclass

endpackage

// ----- verif/tb_lfu_cache.sv -----
`timescale 1ns / 1ps
// Top of the lfu_cache testbench: clock, reset, stream and register drivers, result monitor.
module tb_lfu_cache;
   import lfu_pkg::*;
   import lfu_cache_tb_pkg::*;

   localparam int LATENCY     = SLOTS + 3;
   localparam int LONG_STALL  = 300;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 250;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   lfu_scoreboard sb;
   bit            req_idle_on;
   bit            rsp_idle_on;
   bit            stall_toggle = 1'b0;
   bit            stall_seen = 1'b0;
   int unsigned   cycle_count;
   logic [4:0]    phase_caps [8];
   logic [31:0]   cap_word;
   int            live_limit;

   lfu_cache #(.ENTRIES(SLOTS)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [31:0] key, [63:32] value
      .req_tuser   (req_tuser),    // [0] req_type
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [31:0] read_value, [63:32] evicted_key
      .rsp_tuser   (rsp_tuser),    // [0] hit, [1] evicted
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tuser[0], rsp_tdata[31:0], rsp_tuser[1], rsp_tdata[63:32]);
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** lfu_cache: FAILED **");
      $finish;
   end

   // Result side: short random stalls, plus one long hold-off whenever the toggle flips.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_toggle != stall_seen) begin
            stall_seen = stall_toggle;
            rsp_tready <= 1'b0;
            repeat (LONG_STALL - 1) @(negedge clock);
         end else if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Entered and left at a falling edge; tvalid stays high into the next item.
   task automatic send_request(input logic kind, input logic [31:0] key,
                               input logic [31:0] value);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {value, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, key, value);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.pending_count() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   // Writes the capacity register, then reads it back.
   task automatic write_capacity(input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_CAPACITY;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_capacity(data);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== {27'd0, data[4:0]}) begin
         $error("field capacity: expected %08h, actual %08h", {27'd0, data[4:0]}, csr_prdata);
         sb.error_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Keys come mostly from a small pool so that hits, updates and evictions are frequent.
   task automatic run_phase(input int count, input int pool_size, input bit long_stall);
      logic [31:0] pool [$];
      logic [31:0] key;
      logic        kind;
      repeat (pool_size) pool.push_back($urandom);
      for (int i = 0; i < count; i++) begin
         kind = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 9) == 0) key = $urandom;
         else key = pool[$urandom_range(0, pool_size - 1)];
         send_request(kind, key, $urandom);
         if (long_stall && i == count / 3) stall_toggle = ~stall_toggle;
      end
   endtask

   initial begin
      sb = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = REQ_GET;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = CSR_ADDR_CAPACITY;
      csr_pwdata  = '0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      phase_caps  = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'($urandom_range(2, 15)), 5'd17, 5'd16};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset capacity: extremes of keys and values, misses, hits and an update.
      send_request(REQ_GET, 32'h0000_0000, 32'h1234_5678);
      send_request(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(REQ_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(REQ_GET, 32'h8000_0000, 32'hFFFF_FFFF);
      send_request(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(REQ_PUT, 32'h7FFF_FFFF, 32'h5A5A_A5A5);
      send_request(REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      send_request(REQ_GET, 32'h0000_0001, 32'h0000_0000);

      // Capacity below the live count: one victim per insert, then an equal-count tie.
      drain_results();
      write_capacity(32'd2);
      send_request(REQ_PUT, 32'h0000_0002, 32'h0000_0002);
      send_request(REQ_PUT, 32'h0000_0003, 32'h0000_0003);
      send_request(REQ_PUT, 32'h0000_0004, 32'h0000_0004);
      send_request(REQ_GET, 32'h0000_0004, 32'h0000_0000);
      send_request(REQ_PUT, 32'h0000_0005, 32'h0000_0005);

      // Capacity zero behaves as one.
      drain_results();
      write_capacity(32'hFFFF_FFE0);
      send_request(REQ_PUT, 32'h0000_0006, 32'h0000_0006);
      send_request(REQ_PUT, 32'h0000_0007, 32'h0000_0007);
      send_request(REQ_GET, 32'h0000_0006, 32'h0000_0000);

      // Capacity above the slot count saturates.
      drain_results();
      write_capacity(32'h0000_001F);
      send_request(REQ_PUT, 32'h0000_0008, 32'h0000_0008);
      send_request(REQ_GET, 32'h0000_0007, 32'h0000_0000);

      foreach (phase_caps[p]) begin
         drain_results();
         cap_word = $urandom;
         cap_word[4:0] = phase_caps[p];
         write_capacity(cap_word);
         live_limit = (phase_caps[p] == 5'd0) ? 1 :
                      ((phase_caps[p] > SLOTS) ? SLOTS : phase_caps[p]);
         if (p == $size(phase_caps) - 1) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end
         run_phase(PHASE_ITEMS, live_limit + $urandom_range(1, 6), p == 2);
      end

      drain_results();
      if (sb.error_count == 0)
         $display("** lfu_cache: PASSED **");
      else
         $display("** lfu_cache: FAILED **");
      $finish;
   end

endmodule
